// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("%m: assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/oaht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_pkg
// shared types and codes of the open addressing hash table
// ----------------------------------------------------------------------------
package oaht_pkg;

	localparam int KEY_W  = 64;
	localparam int VAL_W  = 64;
	localparam int LIVE_W = 9;
	localparam int HASH_W = 30;

	localparam logic [KEY_W-1:0] KEY_EMPTY = 64'd0;
	localparam logic [KEY_W-1:0] KEY_TOMB  = 64'd1;

	localparam logic [LIVE_W-1:0] LOAD_LIMIT_RST = 9'd192;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_SET    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_HIT         = 3'd0,
		STAT_MISS        = 3'd1,
		STAT_INSERTED    = 3'd2,
		STAT_OVERWRITTEN = 3'd3,
		STAT_REMOVED     = 3'd4,
		STAT_FULL        = 3'd5,
		STAT_INVALID     = 3'd6,
		STAT_CLEARED     = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLEAR,
		S_HASH,
		S_RD,
		S_CHK,
		S_VRD,
		S_DONE
	} state_t;

	// hash unit result
	typedef struct packed {
		logic              done;
		logic [HASH_W-1:0] hash;
	} hash_res_t;

endpackage

// File: sv/open_addressing_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// key/value map with linear probing and tombstones over slot memories
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one request: tuser is the command (lookup, set, remove,
//   clear), tdata holds key and value. m_axis returns one result per request:
//   tuser is the status, tdata holds the value read and the live key count.
//   cfg writes the load limit and is always ready; write it only while idle.
// operation
//   one request at a time. a keyed request is hashed, then each probed slot
//   is read from the key memory and then compared; a lookup hit adds a
//   value read, and the result is then posted to the output register.
//   a clear sweeps the key memory one slot a cycle; reserved keys skip the
//   hash and go straight to the result.
// reset
//   after reset the key memory is swept to empty while s_axis_tready
//   stays low; load limit returns to 192, live count to zero.
// stall
//   the result sits in an output register; a stalled receiver holds the
//   next result in the done state and blocks new requests until taken.
// ----------------------------------------------------------------------------
module open_addressing_hash_table
	import oaht_pkg::*;
#(
	parameter int SLOT_COUNT = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	// request channel
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // key [63:0], value_in [127:64]
	input  logic [1:0]   s_axis_tuser,  // command [1:0]
	// result channel
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [79:0]  m_axis_tdata,  // value_out [63:0], live_count_out [72:64], zero fill
	output logic [2:0]   m_axis_tuser,  // status [2:0]
	// load limit register
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [8:0]   cfg_data       // load_limit [8:0]
);

	`include "assert_macros.svh"

	localparam int IW = $clog2(SLOT_COUNT);

	// control state
	state_t state_q, state_d;
	logic [IW-1:0] sweep_q;
	logic          clr_resp_q;
	logic [LIVE_W-1:0] live_count_q;
	logic [LIVE_W-1:0] load_limit_q;

	// request held for the probe
	cmd_t              cmd_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	logic [IW-1:0]     idx_q;
	logic [IW-1:0]     n_q;
	logic              tomb_seen_q;
	logic [IW-1:0]     tomb_idx_q;
	status_t           status_q;

	// output register
	logic              out_valid_q;
	status_t           out_status_q;
	logic [VAL_W-1:0]  out_value_q;
	logic [LIVE_W-1:0] out_live_q;

	// incoming request fields
	cmd_t             in_cmd;
	logic [KEY_W-1:0] in_key;
	logic             in_reserved;
	logic             accept;

	// memories and hash
	logic              key_we, key_re, val_we, val_re;
	logic [IW-1:0]     key_waddr, val_waddr, key_raddr;
	logic [KEY_W-1:0]  key_wdata, key_rdata;
	logic [VAL_W-1:0]  val_rdata;
	logic              hash_start;
	hash_res_t         hash_res;

	// probe decision
	logic    k_empty, k_tomb, k_match, n_last, fin, have_slot, full_cond;
	logic    do_insert, do_remove;
	logic [IW-1:0] where;
	status_t chk_status;
	logic    out_free;

	assign in_cmd      = cmd_t'(s_axis_tuser);
	assign in_key      = s_axis_tdata[63:0];
	assign in_reserved = (in_key == KEY_EMPTY) || (in_key == KEY_TOMB);
	assign accept      = s_axis_tvalid && s_axis_tready;
	assign out_free    = !out_valid_q || m_axis_tready;
	assign cfg_ready   = 1'b1;

	oaht_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (in_key),
		.res    (hash_res)
	);

	oaht_ram #(.WIDTH(KEY_W), .DEPTH(SLOT_COUNT)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.re    (key_re),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	oaht_ram #(.WIDTH(VAL_W), .DEPTH(SLOT_COUNT)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_q),
		.re    (val_re),
		.raddr (idx_q),
		.rdata (val_rdata)
	);

	// compare of the slot just read against the request
	always_comb begin
		k_empty   = (key_rdata == KEY_EMPTY);
		k_tomb    = (key_rdata == KEY_TOMB);
		k_match   = (key_rdata == key_q);
		n_last    = (n_q == {IW{1'b1}});
		fin       = k_empty || k_match || n_last;
		// a key match keeps its own slot, else the first tombstone wins, else the slot in hand
		where     = (!k_match && tomb_seen_q) ? tomb_idx_q : idx_q;
		have_slot = k_match || k_empty || tomb_seen_q || k_tomb;
		full_cond = (live_count_q >= load_limit_q) || !have_slot;
		do_insert = (cmd_q == CMD_SET) && !k_match && !full_cond;
		do_remove = (cmd_q == CMD_REMOVE) && k_match;
		case (cmd_q)
			CMD_LOOKUP: chk_status = k_match ? STAT_HIT : STAT_MISS;
			CMD_SET: begin
				if (k_match) chk_status = STAT_OVERWRITTEN;
				else if (full_cond) chk_status = STAT_FULL;
				else chk_status = STAT_INSERTED;
			end
			CMD_REMOVE: chk_status = k_match ? STAT_REMOVED : STAT_MISS;
			default: chk_status = STAT_MISS;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					if (in_cmd == CMD_CLEAR) state_d = S_CLEAR;
					else if (in_reserved) state_d = S_DONE;
					else state_d = S_HASH;
				end
			end
			S_CLEAR: begin
				if (sweep_q == {IW{1'b1}}) state_d = clr_resp_q ? S_DONE : S_IDLE;
			end
			S_HASH: begin
				if (hash_res.done) state_d = S_RD;
			end
			S_RD: state_d = S_CHK;
			S_CHK: begin
				if (!fin) state_d = S_RD;
				else if (cmd_q == CMD_LOOKUP && k_match) state_d = S_VRD;
				else state_d = S_DONE;
			end
			S_VRD: state_d = S_DONE;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory and handshake controls
	always_comb begin
		s_axis_tready = 1'b0;
		hash_start    = 1'b0;
		key_we        = 1'b0;
		key_waddr     = sweep_q;
		key_wdata     = KEY_EMPTY;
		key_re        = 1'b0;
		key_raddr     = idx_q;
		val_we        = 1'b0;
		val_waddr     = where;
		val_re        = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				hash_start    = s_axis_tvalid && (in_cmd != CMD_CLEAR) && !in_reserved;
			end
			S_CLEAR: key_we = 1'b1;
			S_RD:    key_re = 1'b1;
			S_CHK: begin
				key_we    = fin && (do_insert || do_remove);
				key_waddr = where;
				key_wdata = (cmd_q == CMD_SET) ? key_q : KEY_TOMB;
				val_we    = fin && (cmd_q == CMD_SET) && (k_match || do_insert);
			end
			S_VRD:   val_re = 1'b1;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			sweep_q      <= '0;
			clr_resp_q   <= 1'b0;
			live_count_q <= '0;
			load_limit_q <= LOAD_LIMIT_RST;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) load_limit_q <= cfg_data;
			if (state_q == S_CLEAR) sweep_q <= sweep_q + 1'b1;
			if (accept && in_cmd == CMD_CLEAR) begin
				clr_resp_q   <= 1'b1;
				sweep_q      <= '0;
				live_count_q <= '0;
			end
			if (state_q == S_CHK && fin) begin
				if (do_insert) live_count_q <= live_count_q + 1'b1;
				else if (do_remove && live_count_q != '0) live_count_q <= live_count_q - 1'b1;
			end
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= in_cmd;
			key_q    <= in_key;
			val_q    <= s_axis_tdata[127:64];
			status_q <= (in_cmd == CMD_CLEAR) ? STAT_CLEARED : STAT_INVALID;
		end
		if (state_q == S_HASH && hash_res.done) begin
			idx_q       <= hash_res.hash[IW-1:0];
			n_q         <= '0;
			tomb_seen_q <= 1'b0;
		end
		if (state_q == S_CHK) begin
			status_q <= chk_status;
			if (!fin) begin
				idx_q <= idx_q + 1'b1;
				n_q   <= n_q + 1'b1;
				if (k_tomb && !tomb_seen_q) begin
					tomb_seen_q <= 1'b1;
					tomb_idx_q  <= idx_q;
				end
			end
		end
		if (state_q == S_DONE && out_free) begin
			out_status_q <= status_q;
			out_value_q  <= (status_q == STAT_HIT) ? val_rdata : '0;
			out_live_q   <= live_count_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {7'd0, out_live_q, out_value_q};

	// accepted request always leaves idle
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, state_q != S_IDLE)
	// hash result only arrives while waiting for it
	`ASSERT_IMPLIES(a_hash_when_wait, clk, arst_n, hash_res.done, state_q == S_HASH)
	// a new result only comes from the done state
	`ASSERT_IMPLIES(a_out_from_done, clk, arst_n, $rose(m_axis_tvalid), $past(state_q) == S_DONE)
	// live count moves by one or clears
	`ASSERT_ALWAYS(a_live_step, clk, arst_n, live_count_q == $past(live_count_q) || live_count_q == $past(live_count_q) + 9'd1 || live_count_q == $past(live_count_q) - 9'd1 || live_count_q == '0)

endmodule

// File: sv/oaht_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module oaht_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/oaht_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_hash
// three stage 64-bit integer mix, result masked to 30 bits
// ----------------------------------------------------------------------------
module oaht_hash
	import oaht_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] key,
	output hash_res_t        res
);

	logic [KEY_W-1:0] a, b, c, d, e, f;
	logic [KEY_W-1:0] mix_s1, mix_s2;
	logic [HASH_W-1:0] hash_s3;
	logic v_s1, v_s2, v_s3;

	always_comb begin
		a = ~key + (key << 18);
		b = a ^ (a >> 31);
		// times 21 as shift and add
		c = mix_s1 + (mix_s1 << 2) + (mix_s1 << 4);
		d = c ^ (c >> 11);
		e = mix_s2 + (mix_s2 << 6);
		f = e ^ (e >> 22);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		mix_s1  <= b;
		mix_s2  <= d;
		hash_s3 <= f[HASH_W-1:0];
	end

	assign res.done = v_s3;
	assign res.hash = hash_s3;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open addressing hash table testbench
// drives lookup, set, remove and clear requests over the stream interface,
// predicts every result with a local linear probing map and compares fields
// ----------------------------------------------------------------------------
module testbench;
	import oaht_pkg::*;

	localparam int SLOTS = 256;
	localparam int WATCHDOG_LIMIT = 20000;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [79:0]  m_axis_tdata;
	logic [2:0]   m_axis_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [8:0]   cfg_data;

	open_addressing_hash_table #(.SLOT_COUNT(SLOTS)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// one expected result
	typedef struct packed {
		status_t     status;
		logic [63:0] value;
		logic [8:0]  live;
	} answer_t;

	// one directed row: check_it set means the typed answer is compared too
	typedef struct {
		cmd_t        cmd;
		logic [63:0] key;
		logic [63:0] value;
		logic        check_it;
		status_t     status;
		logic [8:0]  live;
	} row_t;

	// local copy of the map state
	logic [63:0] map_keys [SLOTS];
	logic [63:0] map_vals [SLOTS];
	logic [8:0]  map_live;
	logic [8:0]  map_limit;

	answer_t answers_due [$];
	int      errors;
	int      idle_pct;
	int      stall_pct;
	int      quiet_cycles;
	logic [63:0] used_keys [$];

	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	// hash of a key down to its home slot
	function automatic int home_slot(input logic [63:0] k);
		logic [63:0] h;
		h = ~k + (k << 18);
		h = h ^ (h >> 31);
		h = h * 64'd21;
		h = h ^ (h >> 11);
		h = h + (h << 6);
		h = h ^ (h >> 22);
		return int'(h[29:0]) % SLOTS;
	endfunction

	// applies one request to the local map and returns the result it causes
	function automatic answer_t map_apply(input cmd_t cmd, input logic [63:0] k,
			input logic [63:0] v);
		answer_t a;
		int idx, where, tomb_idx;
		bit tomb_seen, hit, have_slot, stop;
		a.value = '0;
		hit = 0;
		have_slot = 0;
		where = 0;
		if (cmd == CMD_CLEAR) begin
			foreach (map_keys[i]) begin
				map_keys[i] = KEY_EMPTY;
				map_vals[i] = '0;
			end
			map_live = '0;
			a.status = STAT_CLEARED;
		end else if (k == KEY_EMPTY || k == KEY_TOMB) begin
			a.status = STAT_INVALID;
		end else begin
			idx = home_slot(k);
			tomb_seen = 0;
			tomb_idx = 0;
			stop = 0;
			for (int n = 0; n < SLOTS && !stop; n++) begin
				if (map_keys[idx] == KEY_EMPTY) begin
					where = tomb_seen ? tomb_idx : idx;
					have_slot = 1;
					stop = 1;
				end else if (map_keys[idx] == KEY_TOMB) begin
					if (!tomb_seen) begin
						tomb_seen = 1;
						tomb_idx = idx;
					end
				end else if (map_keys[idx] == k) begin
					where = idx;
					have_slot = 1;
					hit = 1;
					stop = 1;
				end
				idx = (idx + 1) % SLOTS;
			end
			if (!stop) begin
				where = tomb_idx;
				have_slot = tomb_seen;
			end
			case (cmd)
				CMD_LOOKUP: begin
					a.status = hit ? STAT_HIT : STAT_MISS;
					if (hit) a.value = map_vals[where];
				end
				CMD_SET: begin
					if (hit) begin
						map_vals[where] = v;
						a.status = STAT_OVERWRITTEN;
					end else if (map_live >= map_limit || !have_slot) begin
						a.status = STAT_FULL;
					end else begin
						map_keys[where] = k;
						map_vals[where] = v;
						map_live++;
						a.status = STAT_INSERTED;
					end
				end
				default: begin
					if (hit) begin
						map_keys[where] = KEY_TOMB;
						map_vals[where] = '0;
						if (map_live > 0) map_live--;
						a.status = STAT_REMOVED;
					end else begin
						a.status = STAT_MISS;
					end
				end
			endcase
		end
		a.live = map_live;
		return a;
	endfunction

	// sends one request, holding tvalid until accepted; idles first at random
	// tvalid stays high after acceptance until drain or an idle in the next call lowers it
	task automatic send_request(input cmd_t cmd, input logic [63:0] k, input logic [63:0] v);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {v, k};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		answers_due.push_back(map_apply(cmd, k, v));
	endtask

	// waits for all results, then for a trailing clear sweep
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (SLOTS * 2 + 20) @(posedge clk);
	endtask

	// writes the load limit while the block is idle
	task automatic write_limit(input logic [8:0] lim);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= lim;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		map_limit = lim;
	endtask

	// random key: mostly reused ones so that hits and removes happen
	function automatic logic [63:0] pick_key();
		logic [63:0] k;
		int r;
		r = $urandom_range(99);
		if (r < 3) return 64'(r % 2);
		if (used_keys.size() != 0 && r < 60)
			return used_keys[$urandom_range(used_keys.size() - 1)];
		k = {$urandom, $urandom};
		if (r < 70) k = 64'($urandom_range(300));
		used_keys.push_back(k);
		return k;
	endfunction

	task automatic random_phase(input int count);
		cmd_t cmd;
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			cmd = r < 35 ? CMD_LOOKUP : r < 75 ? CMD_SET : r < 99 ? CMD_REMOVE : CMD_CLEAR;
			send_request(cmd, pick_key(), {$urandom, $urandom});
		end
	endtask

	// receiver: random stalls, compares each result with the oldest expectation
	always @(posedge clk) begin
		answer_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (answers_due.size() == 0) begin
					report("unexpected result", m_axis_tdata[63:0], '0);
				end else begin
					want = answers_due.pop_front();
					if (m_axis_tuser != want.status) report("status", m_axis_tuser, want.status);
					if (m_axis_tdata[63:0] != want.value)
						report("value_out", m_axis_tdata[63:0], want.value);
					if (m_axis_tdata[72:64] != want.live)
						report("live_count_out", m_axis_tdata[72:64], want.live);
				end
			end
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// watchdog on cycles with no accepted request or result
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		row_t rows [$];
		answer_t a;
		errors = 0;
		idle_pct = 0;
		stall_pct = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = CMD_LOOKUP;
		m_axis_tready = 1'b1;
		cfg_valid = 1'b0;
		cfg_data = '0;
		foreach (map_keys[i]) begin
			map_keys[i] = KEY_EMPTY;
			map_vals[i] = '0;
		end
		map_live = '0;
		map_limit = LOAD_LIMIT_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: reserved keys, extremes, every command
		rows = '{
			'{CMD_LOOKUP, 64'd5, 64'd0, 1'b1, STAT_MISS, 9'd0},
			'{CMD_LOOKUP, 64'd0, 64'd0, 1'b1, STAT_INVALID, 9'd0},
			'{CMD_SET, 64'd1, 64'hffff_ffff_ffff_ffff, 1'b1, STAT_INVALID, 9'd0},
			'{CMD_REMOVE, 64'd0, 64'd0, 1'b1, STAT_INVALID, 9'd0},
			'{CMD_REMOVE, 64'd9, 64'd0, 1'b1, STAT_MISS, 9'd0},
			'{CMD_SET, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1,
				STAT_INSERTED, 9'd1},
			'{CMD_SET, 64'd2, 64'h0, 1'b1, STAT_INSERTED, 9'd2},
			'{CMD_LOOKUP, 64'hffff_ffff_ffff_ffff, 64'd0, 1'b0, STAT_HIT, 9'd0},
			'{CMD_SET, 64'd2, 64'haaaa_5555_aaaa_5555, 1'b1, STAT_OVERWRITTEN, 9'd2},
			'{CMD_LOOKUP, 64'd2, 64'd0, 1'b0, STAT_HIT, 9'd0},
			'{CMD_REMOVE, 64'd2, 64'd0, 1'b1, STAT_REMOVED, 9'd1},
			'{CMD_LOOKUP, 64'd2, 64'd0, 1'b1, STAT_MISS, 9'd1},
			'{CMD_SET, 64'd3, 64'h5555_aaaa_5555_aaaa, 1'b0, STAT_INSERTED, 9'd0},
			'{CMD_CLEAR, 64'd77, 64'd1, 1'b1, STAT_CLEARED, 9'd0},
			'{CMD_LOOKUP, 64'd3, 64'd0, 1'b1, STAT_MISS, 9'd0}
		};
		foreach (rows[i]) begin
			send_request(rows[i].cmd, rows[i].key, rows[i].value);
			if (rows[i].check_it) begin
				a = answers_due[$];
				if (a.status != rows[i].status || a.live != rows[i].live)
					report("directed row", i, rows[i].status);
			end
		end

		// load limit extremes: zero refuses all, one allows a single key
		write_limit(9'd0);
		send_request(CMD_SET, 64'd10, 64'd1);
		write_limit(9'd1);
		send_request(CMD_SET, 64'd10, 64'd1);
		send_request(CMD_SET, 64'd11, 64'd1);

		// limit above slot count: fill every slot, then tombstone wrap
		write_limit(9'd511);
		idle_pct = 0;
		for (int i = 0; i < SLOTS + 2; i++) send_request(CMD_SET, 64'(i + 100), 64'(i));
		for (int i = 0; i < 8; i++) send_request(CMD_REMOVE, 64'(i * 3 + 100), 64'd0);
		send_request(CMD_LOOKUP, 64'd5000, 64'd0);
		for (int i = 0; i < 9; i++) send_request(CMD_SET, 64'(i + 7000), 64'(i));
		send_request(CMD_CLEAR, 64'd0, 64'd0);

		// random phases across idling and stall mixes and limits
		write_limit(9'd256);
		idle_pct = 0;  stall_pct = 0;  random_phase(100);
		write_limit(9'd40);
		idle_pct = 64; stall_pct = 0;  random_phase(100);
		write_limit(LOAD_LIMIT_RST);
		idle_pct = 0;  stall_pct = 64; random_phase(100);
		write_limit(9'd300);
		idle_pct = 36; stall_pct = 36; random_phase(100);

		drain();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: open_addressing_hash_table.f
+incdir+sv
sv/oaht_pkg.sv
sv/oaht_ram.sv
sv/oaht_hash.sv
sv/open_addressing_hash_table.sv
verif/testbench.sv
